@@ src/bcd_imu_frame_parser_top_macros.svh @@
// Assertion macros used by the frame parser checker.
`ifndef BCD_IMU_FRAME_PARSER_TOP_MACROS_SVH
`define BCD_IMU_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bip_pkg.sv @@
// Package: constants, types and widths for the BCD IMU frame parser.
`timescale 1ns / 1ps
package bip_pkg;

  localparam logic [7:0] HEADER_BYTE   = 8'h68;
  localparam logic [7:0] SIGN_MASK     = 8'h10;
  localparam logic [7:0] DIGIT_MASK    = 8'h0f;
  localparam logic [7:0] PAYLOAD_FIRST = 8'd3;
  localparam int         PAYLOAD_DEPTH = 9;
  localparam int         VALUE_W       = 19;
  localparam int         MAG_W         = VALUE_W - 1;

  typedef logic [PAYLOAD_DEPTH-1:0][7:0] payload_t;
  typedef logic signed [VALUE_W-1:0]     value_t;

endpackage

@@ src/bip_decode.sv @@
// Signed BCD value decoder: three frame bytes to one two's complement value.
`timescale 1ns / 1ps
module bip_decode (
  input  logic [7:0]      head,
  input  logic [7:0]      mid,
  input  logic [7:0]      low,
  output bip_pkg::value_t value
);
  import bip_pkg::*;

  logic [3:0]       head_digit;
  logic [7:0]       mid_pair;
  logic [7:0]       low_pair;
  logic [MAG_W-1:0] mag;
  logic [VALUE_W-1:0] mag_ext;
  logic             negative;

  always_comb begin
    head_digit = 4'(head & DIGIT_MASK);
    negative   = (head & SIGN_MASK) != 8'd0;
    mid_pair   = ({4'd0, mid[7:4]} * 8'd10) + {4'd0, mid[3:0]};
    low_pair   = ({4'd0, low[7:4]} * 8'd10) + {4'd0, low[3:0]};
    mag        = (MAG_W'(head_digit) * MAG_W'(10000))
               + (MAG_W'(mid_pair) * MAG_W'(100))
               + MAG_W'(low_pair);
    mag_ext    = {1'b0, mag};
    value      = negative ? $signed(VALUE_W'(0) - mag_ext) : $signed(mag_ext);
  end

endmodule

@@ src/bcd_imu_frame_parser_top.sv @@
// Top level of the BCD IMU frame parser: frame tracking, snapshot and result register.
// Takes one word per cycle while in_stall is low; a frame's result passes through the snapshot and result registers.
// Sustained rate is one word per cycle while the result register is not stalled.
// The snapshot and result registers give two slots of buffering behind a stalled output.
// Synchronous reset returns the parser to hunting for a header and empties both slots.
`timescale 1ns / 1ps
module bcd_imu_frame_parser_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      rx_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            checksum_ok,
  output bip_pkg::value_t yaw_rate_centi,
  output bip_pkg::value_t forward_accel_milli,
  output bip_pkg::value_t yaw_angle_centi
);
  import bip_pkg::*;

  logic       in_frame, in_frame_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_sum, running_sum_next;
  payload_t   payload_bytes, payload_bytes_next;

  logic       s1_valid;
  logic       s1_ok;
  payload_t   s1_payload;

  logic       accept;
  logic       advance_out;
  logic       frame_done;
  logic       frame_ok;
  logic [7:0] count_inc;
  logic [7:0] length_now;

  value_t     dec_rate, dec_accel, dec_angle;

  assign advance_out = !out_valid || !out_stall;
  assign in_stall    = s1_valid && !advance_out;
  assign accept      = in_valid && !in_stall;

  always_comb begin
    in_frame_next      = in_frame;
    byte_count_next    = byte_count;
    frame_length_next  = frame_length;
    running_sum_next   = running_sum;
    payload_bytes_next = payload_bytes;
    frame_done         = 1'b0;
    frame_ok           = 1'b0;
    count_inc          = byte_count + 8'd1;
    length_now         = (byte_count == 8'd0) ? rx_byte : frame_length;
    if (accept) begin
      if (!in_frame) begin
        if (rx_byte == HEADER_BYTE) begin
          in_frame_next      = 1'b1;
          byte_count_next    = 8'd0;
          frame_length_next  = 8'd0;
          running_sum_next   = 8'd0;
          payload_bytes_next = '0;
        end
      end else if (byte_count == 8'd0 && rx_byte == 8'd0) begin
        // drop the frame on a zero length
        frame_length_next = 8'd0;
        in_frame_next     = 1'b0;
        byte_count_next   = 8'd0;
      end else begin
        frame_length_next = length_now;
        for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
          if (byte_count == PAYLOAD_FIRST + 8'(i)) begin
            payload_bytes_next[i] = rx_byte;
          end
        end
        if (count_inc == length_now) begin
          frame_done      = 1'b1;
          frame_ok        = (running_sum == rx_byte);
          in_frame_next   = 1'b0;
          byte_count_next = 8'd0;
        end else begin
          running_sum_next = running_sum + rx_byte;
          byte_count_next  = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      byte_count   <= 8'd0;
      frame_length <= 8'd0;
      running_sum  <= 8'd0;
    end else begin
      in_frame     <= in_frame_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    payload_bytes <= payload_bytes_next;
  end

  // snapshot of a finished frame
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_done) begin
      s1_valid <= 1'b1;
    end else if (advance_out) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      s1_ok      <= frame_ok;
      s1_payload <= payload_bytes_next;
    end
  end

  bip_decode u_dec_rate (
    .head  (s1_payload[0]),
    .mid   (s1_payload[1]),
    .low   (s1_payload[2]),
    .value (dec_rate)
  );

  bip_decode u_dec_accel (
    .head  (s1_payload[3]),
    .mid   (s1_payload[4]),
    .low   (s1_payload[5]),
    .value (dec_accel)
  );

  bip_decode u_dec_angle (
    .head  (s1_payload[6]),
    .mid   (s1_payload[7]),
    .low   (s1_payload[8]),
    .value (dec_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance_out) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_out && s1_valid) begin
      checksum_ok         <= s1_ok;
      yaw_rate_centi      <= s1_ok ? dec_rate  : '0;
      forward_accel_milli <= s1_ok ? dec_accel : '0;
      yaw_angle_centi     <= s1_ok ? dec_angle : '0;
    end
  end

endmodule

@@ src/bip_checker.sv @@
// Port-level checker for the BCD IMU frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "bcd_imu_frame_parser_top_macros.svh"
module bip_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic            checksum_ok,
  input bip_pkg::value_t yaw_rate_centi,
  input bip_pkg::value_t forward_accel_milli,
  input bip_pkg::value_t yaw_angle_centi
);
  import bip_pkg::*;

  `BIP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")

  `BIP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(checksum_ok) && $stable(yaw_rate_centi) && $stable(forward_accel_milli) && $stable(yaw_angle_centi), "stalled result word changed")

  `BIP_ASSERT_NOW(a_bad_sum_zero, out_valid && !checksum_ok, yaw_rate_centi == '0 && forward_accel_milli == '0 && yaw_angle_centi == '0, "bad checksum carries nonzero values")

  `BIP_ASSERT_NOW(a_result_has_cause, $rose(out_valid), $past(in_valid && !in_stall, 2), "result word without an accepted input word")

endmodule

bind bcd_imu_frame_parser_top bip_checker u_bip_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .checksum_ok         (checksum_ok),
  .yaw_rate_centi      (yaw_rate_centi),
  .forward_accel_milli (forward_accel_milli),
  .yaw_angle_centi     (yaw_angle_centi)
);
